### hdl/tqps_pkg.sv
// tqps_pkg: shared types and constants for the two-queue task scheduler
// no dependencies
package tqps_pkg;

    localparam int NUM_CPUS_DEF      = 16;
    localparam int QUEUE_DEPTH_DEF   = 64;
    localparam int TASK_ID_BITS_DEF  = 16;
    localparam int PRIORITY_BITS_DEF = 16;

    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_GET     = 2'd1;
    localparam logic [1:0] OP_DISABLE = 2'd2;
    localparam logic [1:0] OP_QUERY   = 2'd3;

    localparam logic [1:0] HINT_NONE      = 2'd0;
    localparam logic [1:0] HINT_CHILD     = 2'd1;
    localparam logic [1:0] HINT_UNBLOCKED = 2'd2;
    localparam logic [1:0] HINT_BUSY_CPU  = 2'd3;

    localparam logic [1:0] PLACED_SLOT      = 2'd0;
    localparam logic [1:0] PLACED_UNBLOCKED = 2'd1;
    localparam logic [1:0] PLACED_READY     = 2'd2;
    localparam logic [1:0] PLACED_NONE      = 2'd3;

    // queue command broadcast to every cell of a chain
    typedef enum logic [1:0] {
        t_QCMD_IDLE,
        t_QCMD_PUSH,
        t_QCMD_POP,
        t_QCMD_POPPUSH
    } t_qcmd;

    typedef enum logic [1:0] {
        t_ST_IDLE,
        t_ST_EXEC,
        t_ST_DONE
    } t_state;

endpackage

### hdl/two_queue_priority_task_scheduler_unit.sv
// two_queue_priority_task_scheduler_unit: top level of the task scheduler
// depends on tqps_pkg, tqps_queue (which uses tqps_cell)
//
// channel  | direction | transfer
// request  | in        | i_start high while o_busy low, fields on i_* ports
// result   | out       | o_done high for one cycle, fields on o_* ports
//
// after acceptance the exec state compares the slot against both queue heads and
// the cell chains shift at the edge that ends it, which completes a push or pop
// the result is on the o_* ports in the next cycle, with o_done high
// o_busy stays high through the result cycle, so a new request is taken only
// after the done state has returned to idle
// synchronous active-low reset empties all slots and both queues; no result stall
module two_queue_priority_task_scheduler_unit #(
    parameter int NUM_CPUS      = tqps_pkg::NUM_CPUS_DEF,
    parameter int QUEUE_DEPTH   = tqps_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_ID_BITS  = tqps_pkg::TASK_ID_BITS_DEF,
    parameter int PRIORITY_BITS = tqps_pkg::PRIORITY_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    output logic                            o_done,
    input  logic [1:0]                      i_operation,
    input  logic [TASK_ID_BITS-1:0]         i_task_id,
    input  logic signed [PRIORITY_BITS-1:0] i_priority_req,
    input  logic [1:0]                      i_hint,
    input  logic                            i_has_cpu,
    input  logic [3:0]                      i_cpu_index,
    input  logic                            i_want_wake,
    input  logic                            i_may_idle,
    input  logic                            i_force_wake,
    output logic                            o_task_valid,
    output logic [TASK_ID_BITS-1:0]         o_served_task,
    output logic signed [PRIORITY_BITS-1:0] o_served_priority,
    output logic [1:0]                      o_placed_in,
    output logic                            o_wake_cpu,
    output logic                            o_cpu_goes_idle,
    output logic                            o_status
);

    localparam int CpuW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

    // source of the served task on a get
    localparam logic [1:0] SRC_NONE      = 2'd0;
    localparam logic [1:0] SRC_SLOT      = 2'd1;
    localparam logic [1:0] SRC_UNBLOCKED = 2'd2;
    localparam logic [1:0] SRC_READY     = 2'd3;

    tqps_pkg::t_state r_state, n_state;

    // captured request
    logic [1:0]                      r_op;
    logic [TASK_ID_BITS-1:0]         r_tid;
    logic signed [PRIORITY_BITS-1:0] r_pri;
    logic [1:0]                      r_hint;
    logic                            r_has_cpu;
    logic [3:0]                      r_cpu;
    logic                            r_want_wake, r_may_idle, r_force_wake;

    // successor slots, one per cpu
    logic                            r_slot_v   [NUM_CPUS];
    logic [TASK_ID_BITS-1:0]         r_slot_id  [NUM_CPUS];
    logic signed [PRIORITY_BITS-1:0] r_slot_pri [NUM_CPUS];

    // result registers
    logic                            r_done, r_tvalid, r_wake, r_idle, r_status;
    logic [TASK_ID_BITS-1:0]         r_sid;
    logic signed [PRIORITY_BITS-1:0] r_spri;
    logic [1:0]                      r_placed;

    // queue control
    tqps_pkg::t_qcmd                 w_rq_cmd, w_uq_cmd;
    logic [TASK_ID_BITS-1:0]         w_rq_nid;
    logic signed [PRIORITY_BITS-1:0] w_rq_npri;
    logic                            w_rq_empty, w_rq_full, w_uq_empty, w_uq_full;
    logic [TASK_ID_BITS-1:0]         w_rq_hid, w_uq_hid;
    logic signed [PRIORITY_BITS-1:0] w_rq_hpri, w_uq_hpri;

    logic                            w_cpu_ok;
    logic [CpuW-1:0]                 w_ci;
    logic                            w_sv;
    logic [TASK_ID_BITS-1:0]         w_sid;
    logic signed [PRIORITY_BITS-1:0] w_spri;

    // per-request combinational decisions in the exec cycle
    logic                            n_done, n_tvalid, n_wake, n_idle, n_status;
    logic [TASK_ID_BITS-1:0]         n_sid;
    logic signed [PRIORITY_BITS-1:0] n_spri;
    logic [1:0]                      n_placed;
    logic                            w_slot_set, w_slot_clr;
    logic [1:0]                      w_best;
    logic signed [PRIORITY_BITS-1:0] w_bp;

    assign w_cpu_ok = ({28'd0, r_cpu} < 32'(NUM_CPUS));
    assign w_ci     = CpuW'(r_cpu);
    assign w_sv     = w_cpu_ok && r_slot_v[w_ci];
    assign w_sid    = r_slot_id[w_ci];
    assign w_spri   = r_slot_pri[w_ci];

    tqps_queue #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .TASK_ID_BITS  (TASK_ID_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_ready (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_rq_cmd),
        .i_new_id   (w_rq_nid),
        .i_new_pri  (w_rq_npri),
        .o_empty    (w_rq_empty),
        .o_full     (w_rq_full),
        .o_head_id  (w_rq_hid),
        .o_head_pri (w_rq_hpri)
    );

    tqps_queue #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .TASK_ID_BITS  (TASK_ID_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_unblocked (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_uq_cmd),
        .i_new_id   (r_tid),
        .i_new_pri  (r_pri),
        .o_empty    (w_uq_empty),
        .o_full     (w_uq_full),
        .o_head_id  (w_uq_hid),
        .o_head_pri (w_uq_hpri)
    );

    // pick the best source, slot first on ties then unblocked then ready
    always_comb begin
        w_best = SRC_NONE;
        w_bp   = '0;
        if (w_sv) begin
            w_best = SRC_SLOT;
            w_bp   = w_spri;
        end
        if (!w_uq_empty && (w_best == SRC_NONE || w_bp < w_uq_hpri)) begin
            w_best = SRC_UNBLOCKED;
            w_bp   = w_uq_hpri;
        end
        if (!w_rq_empty && (w_best == SRC_NONE || w_bp < w_rq_hpri)) begin
            w_best = SRC_READY;
            w_bp   = w_rq_hpri;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_done     = 1'b0;
        n_tvalid   = 1'b0;
        n_sid      = '0;
        n_spri     = '0;
        n_placed   = tqps_pkg::PLACED_NONE;
        n_wake     = 1'b0;
        n_idle     = 1'b0;
        n_status   = 1'b0;
        w_rq_cmd   = tqps_pkg::t_QCMD_IDLE;
        w_uq_cmd   = tqps_pkg::t_QCMD_IDLE;
        w_rq_nid   = r_tid;
        w_rq_npri  = r_pri;
        w_slot_set = 1'b0;
        w_slot_clr = 1'b0;
        unique case (r_state)
            tqps_pkg::t_ST_IDLE: begin
                if (i_start) begin
                    n_state = tqps_pkg::t_ST_EXEC;
                end
            end
            tqps_pkg::t_ST_EXEC: begin
                n_state = tqps_pkg::t_ST_DONE;
                n_done  = 1'b1;
                unique case (r_op)
                    tqps_pkg::OP_ADD: begin
                        if (r_has_cpu && w_cpu_ok && r_hint == tqps_pkg::HINT_NONE
                            && !w_sv) begin
                            w_slot_set = 1'b1;
                            n_placed   = tqps_pkg::PLACED_SLOT;
                        end else if (r_hint == tqps_pkg::HINT_UNBLOCKED) begin
                            if (w_uq_full) begin
                                n_status = 1'b1;
                            end else begin
                                w_uq_cmd = tqps_pkg::t_QCMD_PUSH;
                                n_placed = tqps_pkg::PLACED_UNBLOCKED;
                                n_wake   = r_want_wake;
                            end
                        end else begin
                            if (w_rq_full) begin
                                n_status = 1'b1;
                            end else begin
                                w_rq_cmd = tqps_pkg::t_QCMD_PUSH;
                                n_placed = tqps_pkg::PLACED_READY;
                                n_wake   = r_want_wake;
                            end
                        end
                    end
                    tqps_pkg::OP_GET: begin
                        w_rq_nid  = w_sid;
                        w_rq_npri = w_spri;
                        case (w_best)
                            SRC_SLOT: begin
                                n_tvalid   = 1'b1;
                                n_sid      = w_sid;
                                n_spri     = w_spri;
                                w_slot_clr = 1'b1;
                            end
                            SRC_UNBLOCKED: begin
                                n_tvalid = 1'b1;
                                n_sid    = w_uq_hid;
                                n_spri   = w_uq_hpri;
                                w_uq_cmd = tqps_pkg::t_QCMD_POP;
                                if (w_sv && !w_rq_full) begin
                                    w_rq_cmd   = tqps_pkg::t_QCMD_PUSH;
                                    w_slot_clr = 1'b1;
                                end
                            end
                            SRC_READY: begin
                                n_tvalid = 1'b1;
                                n_sid    = w_rq_hid;
                                n_spri   = w_rq_hpri;
                                if (w_sv) begin
                                    w_rq_cmd   = tqps_pkg::t_QCMD_POPPUSH;
                                    w_slot_clr = 1'b1;
                                end else begin
                                    w_rq_cmd = tqps_pkg::t_QCMD_POP;
                                end
                            end
                            default: begin
                                n_idle = r_may_idle;
                            end
                        endcase
                    end
                    tqps_pkg::OP_DISABLE: begin
                        w_rq_nid  = w_sid;
                        w_rq_npri = w_spri;
                        if (w_sv) begin
                            if (w_rq_full) begin
                                n_status = 1'b1;
                            end else begin
                                w_rq_cmd   = tqps_pkg::t_QCMD_PUSH;
                                w_slot_clr = 1'b1;
                            end
                        end
                    end
                    tqps_pkg::OP_QUERY: begin
                        n_wake = r_force_wake || !w_rq_empty || !w_uq_empty;
                    end
                    default: ;
                endcase
            end
            tqps_pkg::t_ST_DONE: begin
                n_state = tqps_pkg::t_ST_IDLE;
            end
            default: n_state = tqps_pkg::t_ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tqps_pkg::t_ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // request capture and result registers: payload only
    always_ff @(posedge i_clk) begin
        if (r_state == tqps_pkg::t_ST_IDLE && i_start) begin
            r_op         <= i_operation;
            r_tid        <= i_task_id;
            r_pri        <= i_priority_req;
            r_hint       <= i_hint;
            r_has_cpu    <= i_has_cpu;
            r_cpu        <= i_cpu_index;
            r_want_wake  <= i_want_wake;
            r_may_idle   <= i_may_idle;
            r_force_wake <= i_force_wake;
        end
        if (n_done) begin
            r_tvalid <= n_tvalid;
            r_sid    <= n_sid;
            r_spri   <= n_spri;
            r_placed <= n_placed;
            r_wake   <= n_wake;
            r_idle   <= n_idle;
            r_status <= n_status;
        end
    end

    for (genvar c = 0; c < NUM_CPUS; c++) begin : g_slot
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_slot_v[c] <= 1'b0;
            end else if (w_ci == CpuW'(c) && w_cpu_ok) begin
                if (w_slot_set) begin
                    r_slot_v[c] <= 1'b1;
                end else if (w_slot_clr) begin
                    r_slot_v[c] <= 1'b0;
                end
            end
            if (w_slot_set && w_ci == CpuW'(c)) begin
                r_slot_id[c]  <= r_tid;
                r_slot_pri[c] <= r_pri;
            end
        end
    end

    assign o_busy            = (r_state != tqps_pkg::t_ST_IDLE);
    assign o_done            = r_done;
    assign o_task_valid      = r_tvalid;
    assign o_served_task     = r_sid;
    assign o_served_priority = r_spri;
    assign o_placed_in       = r_placed;
    assign o_wake_cpu        = r_wake;
    assign o_cpu_goes_idle   = r_idle;
    assign o_status          = r_status;

endmodule

### hdl/tqps_cell.sv
// tqps_cell: one entry of a sorted queue chain
// depends on tqps_pkg
module tqps_cell #(
    parameter int TASK_ID_BITS  = tqps_pkg::TASK_ID_BITS_DEF,
    parameter int PRIORITY_BITS = tqps_pkg::PRIORITY_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tqps_pkg::t_qcmd                 i_cmd,
    input  logic [TASK_ID_BITS-1:0]         i_new_id,
    input  logic signed [PRIORITY_BITS-1:0] i_new_pri,
    // neighbor toward the head
    input  logic                            i_up_valid,
    input  logic                            i_up_ge,
    input  logic [TASK_ID_BITS-1:0]         i_up_id,
    input  logic signed [PRIORITY_BITS-1:0] i_up_pri,
    // neighbor toward the tail
    input  logic                            i_dn_valid,
    input  logic [TASK_ID_BITS-1:0]         i_dn_id,
    input  logic signed [PRIORITY_BITS-1:0] i_dn_pri,
    output logic                            o_valid,
    output logic                            o_ge,
    output logic                            o_ge_after_pop,
    output logic [TASK_ID_BITS-1:0]         o_id,
    output logic signed [PRIORITY_BITS-1:0] o_pri
);

    logic                            r_valid;
    logic [TASK_ID_BITS-1:0]         r_id;
    logic signed [PRIORITY_BITS-1:0] r_pri;
    logic                            n_valid;
    logic [TASK_ID_BITS-1:0]         n_id;
    logic signed [PRIORITY_BITS-1:0] n_pri;

    // entry stays ahead of the new task when its priority is not lower
    assign o_ge = r_valid && (r_pri >= i_new_pri);
    assign o_ge_after_pop = i_dn_valid && (i_dn_pri >= i_new_pri);
    assign o_valid = r_valid;
    assign o_id    = r_id;
    assign o_pri   = r_pri;

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_pri   = r_pri;
        case (i_cmd)
            tqps_pkg::t_QCMD_PUSH: begin
                if (!o_ge) begin
                    if (i_up_ge) begin
                        n_valid = 1'b1;
                        n_id    = i_new_id;
                        n_pri   = i_new_pri;
                    end else if (i_up_valid) begin
                        n_valid = 1'b1;
                        n_id    = i_up_id;
                        n_pri   = i_up_pri;
                    end
                end
            end
            tqps_pkg::t_QCMD_POP: begin
                n_valid = i_dn_valid;
                n_id    = i_dn_id;
                n_pri   = i_dn_pri;
            end
            tqps_pkg::t_QCMD_POPPUSH: begin
                // after the shift this cell would hold the lower neighbor
                if (i_dn_valid && o_ge_after_pop) begin
                    n_valid = 1'b1;
                    n_id    = i_dn_id;
                    n_pri   = i_dn_pri;
                end else if (i_up_ge) begin
                    n_valid = 1'b1;
                    n_id    = i_new_id;
                    n_pri   = i_new_pri;
                end else begin
                    n_valid = r_valid;
                    n_id    = r_id;
                    n_pri   = r_pri;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_id  <= n_id;
        r_pri <= n_pri;
    end

endmodule

### hdl/tqps_queue.sv
// tqps_queue: sorted queue built as a chain of cells, head at cell 0
// depends on tqps_pkg, tqps_cell
module tqps_queue #(
    parameter int QUEUE_DEPTH   = tqps_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_ID_BITS  = tqps_pkg::TASK_ID_BITS_DEF,
    parameter int PRIORITY_BITS = tqps_pkg::PRIORITY_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tqps_pkg::t_qcmd                 i_cmd,
    input  logic [TASK_ID_BITS-1:0]         i_new_id,
    input  logic signed [PRIORITY_BITS-1:0] i_new_pri,
    output logic                            o_empty,
    output logic                            o_full,
    output logic [TASK_ID_BITS-1:0]         o_head_id,
    output logic signed [PRIORITY_BITS-1:0] o_head_pri
);

    logic                            w_valid [QUEUE_DEPTH+1];
    logic                            w_ge    [QUEUE_DEPTH];
    logic                            w_gap   [QUEUE_DEPTH];
    logic [TASK_ID_BITS-1:0]         w_id    [QUEUE_DEPTH+1];
    logic signed [PRIORITY_BITS-1:0] w_pri   [QUEUE_DEPTH+1];

    // virtual cell past the tail: always empty
    assign w_valid[QUEUE_DEPTH] = 1'b0;
    assign w_id[QUEUE_DEPTH]    = '0;
    assign w_pri[QUEUE_DEPTH]   = '0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic                            w_up_valid;
        logic                            w_up_ge;
        logic [TASK_ID_BITS-1:0]         w_up_id;
        logic signed [PRIORITY_BITS-1:0] w_up_pri;
        if (g == 0) begin : g_head
            // above the head: an always-winning empty spot
            assign w_up_valid = 1'b0;
            assign w_up_ge    = 1'b1;
            assign w_up_id    = '0;
            assign w_up_pri   = '0;
        end else begin : g_body
            assign w_up_valid = w_valid[g-1];
            assign w_up_ge    = (i_cmd == tqps_pkg::t_QCMD_POPPUSH) ? w_gap[g-1] : w_ge[g-1];
            assign w_up_id    = w_id[g-1];
            assign w_up_pri   = w_pri[g-1];
        end
        tqps_cell #(
            .TASK_ID_BITS  (TASK_ID_BITS),
            .PRIORITY_BITS (PRIORITY_BITS)
        ) u_cell (
            .i_clk             (i_clk),
            .i_rst_n           (i_rst_n),
            .i_cmd             (i_cmd),
            .i_new_id          (i_new_id),
            .i_new_pri         (i_new_pri),
            .i_up_valid        (w_up_valid),
            .i_up_ge           (w_up_ge),
            .i_up_id           (w_up_id),
            .i_up_pri          (w_up_pri),
            .i_dn_valid        (w_valid[g+1]),
            .i_dn_id           (w_id[g+1]),
            .i_dn_pri          (w_pri[g+1]),
            .o_valid           (w_valid[g]),
            .o_ge              (w_ge[g]),
            .o_ge_after_pop    (w_gap[g]),
            .o_id              (w_id[g]),
            .o_pri             (w_pri[g])
        );
    end

    assign o_empty    = !w_valid[0];
    assign o_full     = w_valid[QUEUE_DEPTH-1];
    assign o_head_id  = w_id[0];
    assign o_head_pri = w_pri[0];

endmodule
